### hdl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// Frame pacing PI controller package
// Shared types, register indexes and fixed-point limits.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_WINDOW_US  = 3'd2;
    localparam logic [2:0] REG_OFFSET_US  = 3'd3;
    localparam logic [2:0] REG_WORKER_K   = 3'd4;

    // Divider geometry: (frame_time << 32) / complexity.
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 40;
    localparam int DIV_CNT_W  = 6;

    // Fixed-point limits.
    localparam logic [31:0] DEFAULT_WINDOW = 32'd1000000;
    localparam logic [50:0] EST_SAT        = 51'h4_0000_0000_0000;
    localparam int          MAX_ERR_Q8     = 12800000;
    localparam int          MAX_SLEEP_Q8   = 12800000;
    localparam logic [47:0] RATIO_CEIL     = 48'hFFFF_FFFF_FFFF;

    // Reciprocal of 20 in Q16, exact for floor over the count range.
    localparam logic [11:0] RECIP_20 = 12'd3277;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_COUNT,
        ST_CAND_RD,
        ST_CAND_WT,
        ST_INNER,
        ST_MUL_H,
        ST_MUL_L,
        ST_EST,
        ST_MUL_P,
        ST_MUL_I,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

### hdl/fpc_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 40 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [fpc_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [fpc_pkg::DIVISOR_W-1:0]   divisor,
    output logic                            done,
    output logic [fpc_pkg::DIVIDEND_W-1:0]  quotient
);
    import fpc_pkg::*;

    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  trial;

    // One shift and trial subtract per cycle.
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIVISOR_W+1]) begin
                rem_next = trial[DIVISOR_W:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {DIV_CNT_W{1'b1}}) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/frame_pacing_pi_controller_unit.sv
// ----------------------------------------------------------------------------
// Frame pacing PI controller
// Turns per-frame cost measurements into a clamped sleep time.
// ----------------------------------------------------------------------------
// Usage: each transaction on the s_ channel carries one frame (complexity,
// measured time, timestamp) and yields exactly one transaction on the m_
// channel: the sleep in whole microseconds and k_used in m_tdata, the
// accepted flag in m_tuser. Frames with zero complexity, zero time or a zero
// ratio are answered with accepted low and leave history and PI untouched.
// A frame with a zero field goes straight to the result stage; any other
// frame is divided first, and a zero ratio ends it there. An accepted frame
// with worker_k set then runs the estimate and the PI update. With worker_k
// zero a counting pass over the history comes first, then each candidate
// entry is fetched and, if it is valid, ranked against the history (fill
// stored entries). The single read port of the history memory serialises
// that search. s_tready is high only in the idle state between frames.
// Reset clears the sequencer, output valid, history fill count and PI state;
// the history memory itself needs no clearing pass. When the receiver stalls
// the result is held in the output register and the next frame is not taken.
// Configuration should only be written while no frame is in flight.
// ----------------------------------------------------------------------------
module frame_pacing_pi_controller_unit #(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input frames.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // complexity[39:0], meas_time_us[71:40], now_us[119:72]
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // sleep[15:0], k_used[63:16]
    output logic         m_tuser,   // accepted[0]
    // Configuration.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import fpc_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    // Configuration registers.
    logic [19:0] prop_gain_reg, integ_gain_reg;
    logic [31:0] window_us_reg;
    logic [20:0] offset_us_reg;
    logic [47:0] worker_k_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    // Sequencer and datapath registers.
    state_t state_reg, state_next;
    logic [39:0] cx_reg, cx_next;
    logic [31:0] ft_reg, ft_next;
    logic [47:0] now_reg, now_next;
    logic [47:0] ratio_reg, ratio_next;
    logic [47:0] k_reg, k_next;
    logic [47:0] cand_reg, cand_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] rank_reg, rank_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] below_reg, below_next;
    logic [CW-1:0] atmost_reg, atmost_next;
    logic          pv_reg, pv_next;
    logic [63:0]   hi_reg, hi_next;
    logic signed [67:0] prod_reg, prod_next;
    logic signed [47:0] pterm_reg, pterm_next;
    logic signed [24:0] err_reg, err_next;
    logic signed [24:0] last_err_reg, last_err_next;
    logic [23:0]   last_sleep_reg, last_sleep_next;
    logic [15:0]   res_sleep_reg, res_sleep_next;
    logic          res_acc_reg, res_acc_next;
    logic [47:0]   res_k_reg, res_k_next;
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_sleep_reg, m_sleep_next;
    logic          m_acc_reg, m_acc_next;
    logic [47:0]   m_k_reg, m_k_next;

    // Control outputs of the sequencer.
    logic          in_take;
    logic          div_start;
    logic          mem_we;
    logic [AW-1:0] rd_addr;

    // History memory.
    logic [47:0] mem_ratio [HISTORY_DEPTH];
    logic [47:0] mem_time  [HISTORY_DEPTH];
    logic [47:0] rd_ratio_reg, rd_time_reg;

    // Divider interface and shared multiplier.
    logic        div_done;
    logic [63:0] div_q;
    logic [47:0] ratio_sat;
    logic signed [40:0] mul_a;
    logic signed [26:0] mul_b;
    logic [31:0]  win;
    logic         rd_valid;
    logic [CW+11:0] rank_prod;
    logic [64:0]  est_sum;
    logic [50:0]  est;
    logic signed [52:0] err_wide;
    logic signed [25:0] err_diff;
    logic signed [49:0] acc;
    logic [33:0]  acc_shift;
    logic [23:0]  sleep_q8;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= 20'd6554;
            integ_gain_reg <= 20'd655;
            window_us_reg  <= DEFAULT_WINDOW;
            offset_us_reg  <= '0;
            worker_k_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata[19:0];
                REG_INTEG_GAIN: integ_gain_reg <= pwdata[19:0];
                REG_WINDOW_US:  window_us_reg  <= pwdata[31:0];
                REG_OFFSET_US:  offset_us_reg  <= pwdata[20:0];
                REG_WORKER_K:   worker_k_reg   <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PROP_GAIN:  prdata = {44'd0, prop_gain_reg};
            REG_INTEG_GAIN: prdata = {44'd0, integ_gain_reg};
            REG_WINDOW_US:  prdata = {32'd0, window_us_reg};
            REG_OFFSET_US:  prdata = {43'd0, offset_us_reg};
            REG_WORKER_K:   prdata = {16'd0, worker_k_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Divider. The operands are loaded from the accepted transaction.
    // ------------------------------------------------------------------
    fpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({s_tdata[71:40], 32'd0}),
        .divisor  (s_tdata[39:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ratio_sat = (div_q[63:48] != 16'd0) ? RATIO_CEIL : div_q[47:0];

    // ------------------------------------------------------------------
    // History memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ratio[wp_reg] <= ratio_sat;
            mem_time[wp_reg]  <= now_reg;
        end
        rd_ratio_reg <= mem_ratio[rd_addr];
        rd_time_reg  <= mem_time[rd_addr];
    end

    // An entry counts when it has a timestamp, a ratio and lies in the window.
    assign win      = (window_us_reg == 32'd0) ? DEFAULT_WINDOW : window_us_reg;
    assign rd_valid = (rd_time_reg != 48'd0) && (rd_ratio_reg != 48'd0) &&
                      ($signed({1'b0, now_reg} - {1'b0, rd_time_reg}) <=
                       $signed({17'd0, win}));

    // ------------------------------------------------------------------
    // Sequencer next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[39:0] == 40'd0 || s_tdata[71:40] == 32'd0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (ratio_sat == 48'd0) begin
                        state_next = ST_DONE;
                    end else if (worker_k_reg != 48'd0) begin
                        state_next = ST_MUL_H;
                    end else begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                if (j_reg == fill_reg && !pv_reg) begin
                    state_next = (n_reg == '0) ? ST_MUL_H : ST_CAND_RD;
                end
            end
            ST_CAND_RD: state_next = ST_CAND_WT;
            ST_CAND_WT: state_next = rd_valid ? ST_INNER : ST_CAND_RD;
            ST_INNER: begin
                if (j_reg == fill_reg && !pv_reg) begin
                    if (below_reg <= rank_reg && rank_reg < atmost_reg) begin
                        state_next = ST_MUL_H;
                    end else begin
                        state_next = ST_CAND_RD;
                    end
                end
            end
            ST_MUL_H: state_next = ST_MUL_L;
            ST_MUL_L: state_next = ST_EST;
            ST_EST:   state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_ACC;
            ST_ACC:   state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs.
    // ------------------------------------------------------------------
    always_comb begin
        in_take   = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        rd_addr   = j_reg[AW-1:0];
        mul_a     = $signed({1'b0, cx_reg});
        mul_b     = $signed({3'd0, k_reg[47:24]});
        case (state_reg)
            ST_IDLE: begin
                in_take   = 1'b1;
                div_start = s_tvalid && s_tdata[39:0] != 40'd0 &&
                            s_tdata[71:40] != 32'd0;
            end
            ST_DIV:     mem_we  = div_done && ratio_sat != 48'd0;
            ST_CAND_RD: rd_addr = i_reg[AW-1:0];
            ST_MUL_L:   mul_b   = $signed({3'd0, k_reg[23:0]});
            ST_MUL_P: begin
                mul_a = $signed({21'd0, prop_gain_reg});
                mul_b = 27'(err_diff);
            end
            ST_MUL_I: begin
                mul_a = $signed({21'd0, integ_gain_reg});
                mul_b = 27'(err_reg);
            end
            default: ;
        endcase
    end

    assign s_tready = in_take;
    assign err_diff = 26'(err_reg) - 26'(last_err_reg);

    // ------------------------------------------------------------------
    // Datapath next values.
    // ------------------------------------------------------------------
    always_comb begin
        cx_next         = cx_reg;
        ft_next         = ft_reg;
        now_next        = now_reg;
        ratio_next      = ratio_reg;
        k_next          = k_reg;
        cand_next       = cand_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        n_next          = n_reg;
        rank_next       = rank_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        below_next      = below_reg;
        atmost_next     = atmost_reg;
        pv_next         = 1'b0;
        hi_next         = hi_reg;
        prod_next       = mul_a * mul_b;
        pterm_next      = pterm_reg;
        err_next        = err_reg;
        last_err_next   = last_err_reg;
        last_sleep_next = last_sleep_reg;
        res_sleep_next  = res_sleep_reg;
        res_acc_next    = res_acc_reg;
        res_k_next      = res_k_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_sleep_next    = m_sleep_reg;
        m_acc_next      = m_acc_reg;
        m_k_next        = m_k_reg;

        rank_prod = (n_reg - 1'b1) * RECIP_20;
        est_sum   = {1'b0, hi_reg} + {25'd0, prod_reg[63:24]};
        est       = (hi_reg >= 64'(EST_SAT) || est_sum > 65'(EST_SAT)) ?
                    EST_SAT : est_sum[50:0];
        err_wide  = $signed({2'b00, est}) - $signed({13'd0, ft_reg, 8'd0}) +
                    ($signed({{32{offset_us_reg[20]}}, offset_us_reg}) <<< 8);
        acc       = $signed({10'd0, last_sleep_reg, 16'd0}) + 50'(pterm_reg) +
                    50'($signed(prod_reg[47:0]));
        acc_shift = acc[49:16];
        sleep_q8  = (acc < 0) ? 24'd0 :
                    (acc_shift > 34'(MAX_SLEEP_Q8)) ? 24'(MAX_SLEEP_Q8) :
                    acc_shift[23:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cx_next        = s_tdata[39:0];
                    ft_next        = s_tdata[71:40];
                    now_next       = s_tdata[119:72];
                    res_sleep_next = '0;
                    res_acc_next   = 1'b0;
                    res_k_next     = '0;
                end
            end
            // Store the new ratio and pick the floor source.
            ST_DIV: begin
                if (div_done && ratio_sat != 48'd0) begin
                    ratio_next = ratio_sat;
                    wp_next    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    if (fill_reg != CW'(HISTORY_DEPTH)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    k_next = worker_k_reg;
                    n_next = '0;
                    j_next = '0;
                    i_next = '0;
                end
            end
            // Count valid entries in the window.
            ST_COUNT: begin
                if (j_reg != fill_reg) begin
                    j_next  = j_reg + 1'b1;
                    pv_next = 1'b1;
                end
                if (pv_reg && rd_valid) begin
                    n_next = n_reg + 1'b1;
                end
                if (j_reg == fill_reg && !pv_reg) begin
                    rank_next = CW'(rank_prod >> 16);
                    k_next    = ratio_reg;
                end
            end
            ST_CAND_RD: ;
            ST_CAND_WT: begin
                cand_next   = rd_ratio_reg;
                i_next      = i_reg + 1'b1;
                j_next      = '0;
                below_next  = '0;
                atmost_next = '0;
            end
            // Rank the candidate against every valid entry.
            ST_INNER: begin
                if (j_reg != fill_reg) begin
                    j_next  = j_reg + 1'b1;
                    pv_next = 1'b1;
                end
                if (pv_reg && rd_valid) begin
                    if (rd_ratio_reg < cand_reg) begin
                        below_next = below_reg + 1'b1;
                    end
                    if (rd_ratio_reg <= cand_reg) begin
                        atmost_next = atmost_reg + 1'b1;
                    end
                end
                if (j_reg == fill_reg && !pv_reg) begin
                    k_next = cand_reg;
                end
            end
            ST_MUL_L: hi_next = prod_reg[63:0];
            // Predicted time and clamped error.
            ST_EST: begin
                if (err_wide > 53'sd12800000) begin
                    err_next = 25'(MAX_ERR_Q8);
                end else if (err_wide < -53'sd12800000) begin
                    err_next = -25'(MAX_ERR_Q8);
                end else begin
                    err_next = err_wide[24:0];
                end
            end
            ST_MUL_I: pterm_next = prod_reg[47:0];
            // Velocity-form PI update.
            ST_ACC: begin
                last_err_next   = err_reg;
                last_sleep_next = sleep_q8;
                res_sleep_next  = sleep_q8[23:8];
                res_acc_next    = 1'b1;
                res_k_next      = k_reg;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_sleep_next = res_sleep_reg;
                    m_acc_next   = res_acc_reg;
                    m_k_next     = res_k_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        cx_reg        <= cx_next;
        ft_reg        <= ft_next;
        now_reg       <= now_next;
        ratio_reg     <= ratio_next;
        k_reg         <= k_next;
        cand_reg      <= cand_next;
        n_reg         <= n_next;
        rank_reg      <= rank_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        below_reg     <= below_next;
        atmost_reg    <= atmost_next;
        hi_reg        <= hi_next;
        prod_reg      <= prod_next;
        pterm_reg     <= pterm_next;
        err_reg       <= err_next;
        res_sleep_reg <= res_sleep_next;
        res_acc_reg   <= res_acc_next;
        res_k_reg     <= res_k_next;
        m_sleep_reg   <= m_sleep_next;
        m_acc_reg     <= m_acc_next;
        m_k_reg       <= m_k_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            fill_reg       <= '0;
            pv_reg         <= 1'b0;
            last_err_reg   <= '0;
            last_sleep_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            pv_reg         <= pv_next;
            last_err_reg   <= last_err_next;
            last_sleep_reg <= last_sleep_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_k_reg, m_sleep_reg};
    assign m_tuser  = m_acc_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("rejected frame carries nonzero result");

    a_sleep_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= 16'd50000)
        else $error("sleep above cap");

    a_k_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[63:16] != 48'd0)
        else $error("accepted frame with zero floor ratio");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(HISTORY_DEPTH))
        else $error("history fill count overflow");

    a_pi_state: assert property (@(posedge aclk) disable iff (!aresetn)
        last_sleep_reg <= 24'(MAX_SLEEP_Q8))
        else $error("stored sleep above cap");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame pacing PI controller testbench
// Sends frames through the stream input and configures the gains, window,
// offset and worker floor over the APB port. A frame-level model forms the
// expected sleep, acceptance and floor ratio for each frame, and every result
// transaction is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
    import fpc_pkg::*;

    localparam int  RING_DEPTH  = 256;
    localparam longint RUN_LIMIT = 40_000_000;
    localparam logic [63:0] EST_CAP = 64'd1 << 50;
    localparam longint ERR_CAP   = 12800000;
    localparam longint SLEEP_CAP = 12800000;

    typedef struct packed {
        logic [15:0] sleep_whole;
        logic        accepted;
        logic [47:0] k_used;
    } pacing_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;   // complexity[39:0], meas_time_us[71:40], now_us[119:72]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // sleep[15:0], k_used[63:16]
    logic         m_tuser;        // accepted[0]
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    frame_pacing_pi_controller_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 aclk = ~aclk;

    // Shadow copy of the configuration and controller state.
    logic [19:0] prop_gain_q;
    logic [19:0] integ_gain_q;
    logic [31:0] window_q;
    logic [20:0] offset_q;
    logic [47:0] worker_k_q;
    logic [47:0] ratio_ring [RING_DEPTH];
    logic [47:0] stamp_ring [RING_DEPTH];
    int          ring_wr;
    int          ring_fill;
    longint      prev_err;
    longint      prev_sleep;

    pacing_result_t pending_results[$];
    int     fail_count = 0;
    longint cycle_count = 0;
    int     burst_left = 0;

    // Low percentile of the valid ratios in the window; zero when none.
    function automatic logic [47:0] window_percentile(logic [47:0] now);
        logic [47:0] cand [RING_DEPTH];
        longint win;
        longint diff;
        int n, rank, idx, below, atmost;
        n = 0;
        win = (window_q == 0) ? 64'd1000000 : longint'(window_q);
        for (int i = 0; i < ring_fill; i++) begin
            idx = (ring_wr + RING_DEPTH - 1 - i) % RING_DEPTH;
            if (stamp_ring[idx] == 0 || ratio_ring[idx] == 0) continue;
            diff = longint'(now) - longint'(stamp_ring[idx]);
            if (diff > win) continue;
            cand[n] = ratio_ring[idx];
            n++;
        end
        if (n == 0) return '0;
        rank = (n - 1) / 20;
        for (int i = 0; i < n; i++) begin
            below = 0;
            atmost = 0;
            for (int j = 0; j < n; j++) begin
                if (cand[j] < cand[i]) below++;
                if (cand[j] <= cand[i]) atmost++;
            end
            if (below <= rank && rank < atmost) return cand[i];
        end
        return cand[0];
    endfunction

    // Expected result of one frame; updates the shadow state on acceptance.
    function automatic pacing_result_t pace_frame(logic [39:0] cx, logic [31:0] ft,
                                                  logic [47:0] now);
        pacing_result_t res;
        logic [63:0] ratio, k, hi, est;
        longint err, acc, sleep_q8;
        res = '0;
        if (cx == 0 || ft == 0) return res;
        ratio = {ft, 32'd0} / {24'd0, cx};
        if (ratio > 64'(RATIO_CEIL)) ratio = 64'(RATIO_CEIL);
        if (ratio == 0) return res;

        stamp_ring[ring_wr] = now;
        ratio_ring[ring_wr] = ratio[47:0];
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;

        k = {16'd0, worker_k_q};
        if (k == 0) k = {16'd0, window_percentile(now)};
        if (k == 0) k = ratio;

        hi = {24'd0, cx} * {40'd0, k[47:24]};
        if (hi >= EST_CAP) begin
            est = EST_CAP;
        end else begin
            est = hi + (({24'd0, cx} * {40'd0, k[23:0]}) >> 24);
            if (est > EST_CAP) est = EST_CAP;
        end
        err = longint'(est) - longint'(ft) * 256 + longint'($signed(offset_q)) * 256;
        if (err > ERR_CAP) err = ERR_CAP;
        if (err < -ERR_CAP) err = -ERR_CAP;

        acc = prev_sleep * 65536 + longint'(prop_gain_q) * (err - prev_err)
            + longint'(integ_gain_q) * err;
        if (acc < 0) begin
            sleep_q8 = 0;
        end else begin
            sleep_q8 = acc >>> 16;
            if (sleep_q8 > SLEEP_CAP) sleep_q8 = SLEEP_CAP;
        end
        prev_err = err;
        prev_sleep = sleep_q8;

        res.sleep_whole = 16'(sleep_q8 >>> 8);
        res.accepted = 1'b1;
        res.k_used = k[47:0];
        return res;
    endfunction

    // APB write: setup cycle, then access cycle; shadow register follows.
    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(index) << 3;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_PROP_GAIN:  prop_gain_q  = value[19:0];
            REG_INTEG_GAIN: integ_gain_q = value[19:0];
            REG_WINDOW_US:  window_q     = value[31:0];
            REG_OFFSET_US:  offset_q     = value[20:0];
            REG_WORKER_K:   worker_k_q   = value[47:0];
            default: ;
        endcase
    endtask

    // Wait until every expected result has come back and the block is idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Send one frame in bursts with random gaps; predict at acceptance.
    task automatic send_frame(logic [39:0] cx, logic [31:0] ft, logic [47:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {now, ft, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(pace_frame(cx, ft, now));
    endtask

    function automatic logic [39:0] rand_complexity();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return 40'(r & ((64'd1 << $urandom_range(1, 40)) - 1)) | 40'd1;
    endfunction

    // Checking of every result transaction against the oldest expectation.
    always @(posedge aclk) begin
        pacing_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h/%b", $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.sleep_whole) begin
                    $display("%0t: sleep expected %0d actual %0d",
                             $time, want.sleep_whole, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tuser !== want.accepted) begin
                    $display("%0t: accepted expected %0b actual %0b",
                             $time, want.accepted, m_tuser);
                    fail_count++;
                end
                if (m_tdata[63:16] !== want.k_used) begin
                    $display("%0t: k_used expected %h actual %h",
                             $time, want.k_used, m_tdata[63:16]);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls: always ready, random stalls, or long periodic stalls.
    always @(posedge aclk) begin
        int stall_mode;
        stall_mode = int'((cycle_count / 97) % 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((cycle_count % 24) < 14);
        endcase
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Rejected frames: zero complexity, zero time, ratio truncating to zero.
    task automatic test_rejects();
        send_frame(40'd0, 32'd5000, 48'd10);
        send_frame(40'd1234, 32'd0, 48'd20);
        send_frame(40'hFF_FFFF_FFFF, 32'd1, 48'd30);
        send_frame(40'd0, 32'd0, 48'd0);
    endtask

    // Field extremes, saturation, empty and out-of-order timestamps.
    task automatic test_extremes();
        send_frame(40'd1, 32'hFFFF_FFFF, 48'd1000);
        send_frame(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'd2000);
        send_frame(40'd100, 32'd16000, 48'd0);
        send_frame(40'd200, 32'd16000, 48'd500);
        send_frame(40'd300, 32'd15000, 48'd3000);
        send_frame(40'd50, 32'd9000, 48'd2500);
        send_frame(40'd1000, 32'd7000, 48'd1_500_000);
        drain_results();
        write_reg(REG_OFFSET_US, 64'(-21'sd1000000));
        write_reg(REG_PROP_GAIN, 64'hF_FFFF);
        write_reg(REG_INTEG_GAIN, 64'd0);
        write_reg(REG_WINDOW_US, 64'd0);
        send_frame(40'd400, 32'd20000, 48'd1_600_000);
        send_frame(40'd400, 32'd30000, 48'd1_700_000);
        drain_results();
        write_reg(REG_OFFSET_US, 64'd1000000);
        write_reg(REG_INTEG_GAIN, 64'hF_FFFF);
        write_reg(REG_WINDOW_US, 64'hFFFF_FFFF);
        send_frame(40'd400, 32'd100, 48'd1_800_000);
        send_frame(40'd7, 32'd3, 48'd1_900_000);
        drain_results();
        write_reg(REG_WINDOW_US, 64'd1000000);
    endtask

    // External floor ratio, including its extremes.
    task automatic test_worker_k();
        write_reg(REG_WORKER_K, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_OFFSET_US, 64'd0);
        send_frame(40'd5000, 32'd4000, 48'd2_000_000);
        drain_results();
        write_reg(REG_WORKER_K, 64'd1);
        write_reg(REG_PROP_GAIN, 64'd6554);
        write_reg(REG_INTEG_GAIN, 64'd655);
        send_frame(40'd5000, 32'd4000, 48'd2_100_000);
        send_frame(40'd64, 32'd90000, 48'd2_200_000);
        drain_results();
    endtask

    // Random frames with a random external worker floor and random timestamps.
    task automatic test_random_worker(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 10 == 0) begin
                drain_results();
                write_reg(REG_WORKER_K, {16'd0, $urandom} | ({$urandom} << 32) & 64'hFFFF_FFFF_FFFF
                          | 64'd1);
                write_reg(REG_PROP_GAIN, 64'($urandom_range(0, 20'hF_FFFF)));
                write_reg(REG_INTEG_GAIN, 64'($urandom_range(0, 20'hF_FFFF)));
                write_reg(REG_OFFSET_US, 64'($signed($urandom_range(0, 2000000)) - 1000000));
            end
            send_frame(($urandom_range(0, 9) == 0) ? 40'd0 : rand_complexity(),
                       ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom,
                       {1'b0, 15'($urandom), $urandom});
        end
        drain_results();
    endtask

    // Random frames with the local estimate over rising timestamps, some left zero.
    task automatic test_random_local(int count);
        logic [47:0] stamp;
        stamp = 48'hE000_0000_0000;
        write_reg(REG_WORKER_K, 64'd0);
        for (int i = 0; i < count; i++) begin
            if (i % 15 == 0) begin
                drain_results();
                write_reg(REG_WINDOW_US, ($urandom_range(0, 4) == 0) ? 64'd0
                          : 64'($urandom_range(200000, 3000000)));
                write_reg(REG_PROP_GAIN, 64'($urandom_range(0, 200000)));
                write_reg(REG_INTEG_GAIN, 64'($urandom_range(0, 200000)));
                write_reg(REG_OFFSET_US, 64'($signed($urandom_range(0, 200000)) - 100000));
            end
            // Hold off once until every outstanding result has returned.
            if (i == count / 2) drain_results();
            stamp = stamp + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 300000)
                                                           : $urandom_range(1000000, 4000000));
            send_frame(($urandom_range(0, 12) == 0) ? 40'd0 : rand_complexity(),
                       ($urandom_range(0, 12) == 0) ? 32'd0 : $urandom,
                       ($urandom_range(0, 20) == 0) ? 48'd0 : stamp);
        end
        drain_results();
    endtask

    initial begin
        prop_gain_q  = 20'd6554;
        integ_gain_q = 20'd655;
        window_q     = 32'd1000000;
        offset_q     = '0;
        worker_k_q   = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ratio_ring[i] = '0;
            stamp_ring[i] = '0;
        end
        ring_wr = 0;
        ring_fill = 0;
        prev_err = 0;
        prev_sleep = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_rejects();
        test_extremes();
        test_worker_k();
        test_random_worker(40);
        test_random_local(60);

        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### frame_pacing_pi_controller_unit.f
hdl/fpc_pkg.sv
hdl/fpc_div.sv
hdl/frame_pacing_pi_controller_unit.sv
tb/sv/tb_top.sv
